@@ rtl/tcf_pkg.sv @@
`default_nettype none
package tcf_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int TABLE_FRAC      = 24;
    localparam int ROUND_SHIFT     = TABLE_FRAC - ANGLE_FRAC_BITS;
    localparam int SQRT_STEPS      = 24;
    localparam int SQRT_W          = 48;
    localparam int XY_W            = 36;
    localparam int Z_W             = 34;
    localparam int IDX_W           = 5;
    localparam int ANG_W           = 17;
    localparam int WIDE_W          = 40;

    localparam logic signed [WIDE_W-1:0] LIMIT = WIDE_W'(180) <<< ANGLE_FRAC_BITS;
    localparam logic [16:0] WEIGHT_ONE = 17'd65536;
    localparam logic [31:0] TIME_SCALE_RST = 32'd2561407;
    localparam logic [16:0] WEIGHT_RST = 17'd62915;

    localparam logic [1:0] REG_ACCEL_OFF  = 2'd0;
    localparam logic [1:0] REG_GYRO_OFF   = 2'd1;
    localparam logic [1:0] REG_TIME_SCALE = 2'd2;
    localparam logic [1:0] REG_WEIGHT     = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_CORDIC,
        ST_ANGLE,
        ST_FUSE,
        ST_ROUND
    } t_state;

    function automatic logic signed [Z_W-1:0] atan_deg(input logic [IDX_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        begin
            unique case (idx)
                5'd0:    v = Z_W'(754974720);
                5'd1:    v = Z_W'(445687602);
                5'd2:    v = Z_W'(235489088);
                5'd3:    v = Z_W'(119537938);
                5'd4:    v = Z_W'(60000934);
                5'd5:    v = Z_W'(30029717);
                5'd6:    v = Z_W'(15018523);
                5'd7:    v = Z_W'(7509720);
                5'd8:    v = Z_W'(3754917);
                5'd9:    v = Z_W'(1877466);
                5'd10:   v = Z_W'(938734);
                5'd11:   v = Z_W'(469367);
                5'd12:   v = Z_W'(234684);
                5'd13:   v = Z_W'(117342);
                5'd14:   v = Z_W'(58671);
                5'd15:   v = Z_W'(29335);
                5'd16:   v = Z_W'(14668);
                5'd17:   v = Z_W'(7334);
                5'd18:   v = Z_W'(3667);
                5'd19:   v = Z_W'(1833);
                5'd20:   v = Z_W'(917);
                5'd21:   v = Z_W'(458);
                5'd22:   v = Z_W'(229);
                5'd23:   v = Z_W'(115);
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [ANG_W-1:0] sat_angle(input logic signed [WIDE_W-1:0] v);
        begin
            if (v > LIMIT) begin
                return ANG_W'(LIMIT);
            end else if (v < -LIMIT) begin
                return ANG_W'(-LIMIT);
            end
            return ANG_W'(v);
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/tilt_complementary_filter.sv @@
// An accepted item passes through 24 square root steps, a hand-over into
// the 16 CORDIC cells, and the ANGLE, FUSE and ROUND states to finish.
// A new item is taken only in idle, once the previous result has been handed
// over in ROUND; a waiting result only holds the final step of the next item.
// Reset (synchronous, active low) clears the pitch estimate, loads the
// register defaults and returns the block to idle.
`default_nettype none
module tilt_complementary_filter (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [15:0] i_accel_x,
    input  wire logic signed [15:0] i_accel_y,
    input  wire logic signed [15:0] i_accel_z,
    input  wire logic signed [15:0] i_gyro_y,
    input  wire logic [15:0]        i_elapsed_ticks,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [16:0]      o_fused_pitch,
    output logic signed [16:0]      o_accel_pitch,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    localparam int N = tcf_pkg::CORDIC_STEPS;

    tcf_pkg::t_state r_state, n_state;
    logic [4:0]  r_cnt;
    logic signed [16:0] r_accel_off;
    logic signed [15:0] r_gyro_off;
    logic [31:0] r_time_scale;
    logic [16:0] r_weight;

    logic signed [15:0] r_ax;
    logic        r_zero;
    logic signed [16:0] r_rate;
    logic [15:0] r_ticks;
    logic [15:0] r_mag;
    logic [31:0] r_p1;
    logic [63:0] r_p2;
    logic signed [33:0] r_inc;
    logic signed [16:0] r_g;
    logic signed [16:0] r_pitch;
    logic signed [16:0] r_acc;
    logic signed [35:0] r_fa;
    logic signed [35:0] r_fb;

    logic        accept;
    logic        wr;
    logic        out_free;
    logic        sq_done;
    logic [23:0] root;
    logic [64:0] p2r;
    logic [16:0] w;
    logic signed [tcf_pkg::XY_W-1:0] c_x [0:N];
    logic signed [tcf_pkg::XY_W-1:0] c_y [0:N];
    logic signed [tcf_pkg::Z_W-1:0]  c_z [0:N];
    logic signed [tcf_pkg::WIDE_W-1:0] zr;
    logic signed [tcf_pkg::WIDE_W-1:0] fsum;

    assign accept   = i_valid && o_ready;
    assign wr       = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign out_free = !o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_off  <= '0;
            r_gyro_off   <= '0;
            r_time_scale <= tcf_pkg::TIME_SCALE_RST;
            r_weight     <= tcf_pkg::WEIGHT_RST;
        end else if (wr) begin
            unique case (paddr[3:2])
                tcf_pkg::REG_ACCEL_OFF:  r_accel_off  <= pwdata[16:0];
                tcf_pkg::REG_GYRO_OFF:   r_gyro_off   <= pwdata[15:0];
                tcf_pkg::REG_TIME_SCALE: r_time_scale <= pwdata;
                tcf_pkg::REG_WEIGHT:     r_weight     <= pwdata[16:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            tcf_pkg::REG_ACCEL_OFF:  prdata = 32'(r_accel_off);
            tcf_pkg::REG_GYRO_OFF:   prdata = 32'(r_gyro_off);
            tcf_pkg::REG_TIME_SCALE: prdata = r_time_scale;
            tcf_pkg::REG_WEIGHT:     prdata = 32'(r_weight);
        endcase
    end

    tcf_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_ay    (i_accel_y),
        .i_az    (i_accel_z),
        .o_done  (sq_done),
        .o_root  (root)
    );

    assign c_x[0] = tcf_pkg::XY_W'({root, 8'd0});
    assign c_y[0] = -(tcf_pkg::XY_W'(r_ax) <<< 16);
    assign c_z[0] = '0;

    for (genvar k = 0; k < N; k++) begin : g_cell
        tcf_cordic_cell u_cell (
            .i_clk (i_clk),
            .i_idx (tcf_pkg::IDX_W'(k)),
            .i_x   (c_x[k]),
            .i_y   (c_y[k]),
            .i_z   (c_z[k]),
            .o_x   (c_x[k+1]),
            .o_y   (c_y[k+1]),
            .o_z   (c_z[k+1])
        );
    end

    // Gyro path settles from the latched item long before the angle is ready.
    assign p2r = 65'(r_p2) + 65'(64'd1 << 31);
    always_ff @(posedge i_clk) begin
        r_mag <= r_rate[16] ? 16'(-r_rate) : r_rate[15:0];
        r_p1  <= 32'(r_mag) * 32'(r_ticks);
        r_p2  <= 64'(r_p1) * 64'(r_time_scale);
        r_inc <= r_rate[16] ? -34'(p2r[63:32]) : 34'(p2r[63:32]);
        r_g   <= tcf_pkg::sat_angle(tcf_pkg::WIDE_W'(r_pitch) + tcf_pkg::WIDE_W'(r_inc));
    end

    assign zr = (tcf_pkg::WIDE_W'(c_z[N]) + (tcf_pkg::WIDE_W'(1) <<< (tcf_pkg::ROUND_SHIFT - 1)))
                >>> tcf_pkg::ROUND_SHIFT;
    assign w = (r_weight > tcf_pkg::WEIGHT_ONE) ? tcf_pkg::WEIGHT_ONE : r_weight;
    assign fsum = (tcf_pkg::WIDE_W'(r_fa) + tcf_pkg::WIDE_W'(r_fb) + tcf_pkg::WIDE_W'(32768))
                  >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcf_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_pitch <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (r_state == tcf_pkg::ST_CORDIC) ? r_cnt + 5'd1 : '0;
            if (r_state == tcf_pkg::ST_ROUND && out_free) begin
                r_pitch <= tcf_pkg::sat_angle(fsum);
                o_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ax    <= i_accel_x;
            r_zero  <= (i_accel_x == '0) && (i_accel_y == '0) && (i_accel_z == '0);
            r_rate  <= 17'(i_gyro_y) - 17'(r_gyro_off);
            r_ticks <= i_elapsed_ticks;
        end
        if (r_state == tcf_pkg::ST_ANGLE) begin
            r_acc <= tcf_pkg::sat_angle((r_zero ? '0 : zr) - tcf_pkg::WIDE_W'(r_accel_off));
        end
        if (r_state == tcf_pkg::ST_FUSE) begin
            r_fa <= 36'(signed'({1'b0, w})) * 36'(r_g);
            r_fb <= 36'(signed'({1'b0, tcf_pkg::WEIGHT_ONE - w})) * 36'(r_acc);
        end
        if (r_state == tcf_pkg::ST_ROUND && out_free) begin
            o_fused_pitch <= tcf_pkg::sat_angle(fsum);
            o_accel_pitch <= r_acc;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        unique case (r_state)
            tcf_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = tcf_pkg::ST_SQRT;
                end
            end
            tcf_pkg::ST_SQRT: begin
                if (sq_done) begin
                    n_state = tcf_pkg::ST_CORDIC;
                end
            end
            tcf_pkg::ST_CORDIC: begin
                if (r_cnt == 5'(N - 1)) begin
                    n_state = tcf_pkg::ST_ANGLE;
                end
            end
            tcf_pkg::ST_ANGLE: n_state = tcf_pkg::ST_FUSE;
            tcf_pkg::ST_FUSE:  n_state = tcf_pkg::ST_ROUND;
            tcf_pkg::ST_ROUND: begin
                if (out_free) begin
                    n_state = tcf_pkg::ST_IDLE;
                end
            end
            default: n_state = tcf_pkg::ST_IDLE;
        endcase
    end

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_fused_pitch)
                                   && $stable(o_accel_pitch)))
        else $error("waiting result changed before it was taken");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second item taken during processing");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (tcf_pkg::WIDE_W'(o_fused_pitch) <= tcf_pkg::LIMIT
                  && tcf_pkg::WIDE_W'(o_fused_pitch) >= -tcf_pkg::LIMIT
                  && tcf_pkg::WIDE_W'(o_accel_pitch) <= tcf_pkg::LIMIT
                  && tcf_pkg::WIDE_W'(o_accel_pitch) >= -tcf_pkg::LIMIT))
        else $error("result outside the angle limit");

endmodule
`default_nettype wire

@@ rtl/tcf_cordic_cell.sv @@
`default_nettype none
module tcf_cordic_cell (
    input  wire logic                              i_clk,
    input  wire logic [tcf_pkg::IDX_W-1:0]         i_idx,
    input  wire logic signed [tcf_pkg::XY_W-1:0]   i_x,
    input  wire logic signed [tcf_pkg::XY_W-1:0]   i_y,
    input  wire logic signed [tcf_pkg::Z_W-1:0]    i_z,
    output logic signed [tcf_pkg::XY_W-1:0]        o_x,
    output logic signed [tcf_pkg::XY_W-1:0]        o_y,
    output logic signed [tcf_pkg::Z_W-1:0]         o_z
);
    logic signed [tcf_pkg::XY_W-1:0] dx;
    logic signed [tcf_pkg::XY_W-1:0] dy;

    assign dx = i_y >>> i_idx;
    assign dy = i_x >>> i_idx;

    always_ff @(posedge i_clk) begin
        if (i_y > 0) begin
            o_x <= i_x + dx;
            o_y <= i_y - dy;
            o_z <= i_z + tcf_pkg::atan_deg(i_idx);
        end else begin
            o_x <= i_x - dx;
            o_y <= i_y + dy;
            o_z <= i_z - tcf_pkg::atan_deg(i_idx);
        end
    end
endmodule
`default_nettype wire

@@ rtl/tcf_isqrt.sv @@
`default_nettype none
module tcf_isqrt (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [15:0] i_ay,
    input  wire logic signed [15:0] i_az,
    output logic                    o_done,
    output logic [23:0]             o_root
);
    logic [tcf_pkg::SQRT_W-1:0] r_v;
    logic [tcf_pkg::SQRT_W-1:0] r_res;
    logic [4:0]                 r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic signed [31:0]         sq_y;
    logic signed [31:0]         sq_z;
    logic [32:0]                sq;
    logic [tcf_pkg::SQRT_W-1:0] bitv;
    logic [tcf_pkg::SQRT_W-1:0] trial;
    logic [5:0]                 sh;

    assign sq_y  = 32'(i_ay) * 32'(i_ay);
    assign sq_z  = 32'(i_az) * 32'(i_az);
    assign sq    = 33'(unsigned'(sq_y)) + 33'(unsigned'(sq_z));
    assign sh    = 6'(tcf_pkg::SQRT_W - 2) - {r_cnt, 1'b0};
    assign bitv  = tcf_pkg::SQRT_W'(1) << sh;
    assign trial = r_res + bitv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_v    <= {sq[31:0], 16'd0};
                r_res  <= '0;
            end else if (r_busy) begin
                if (r_v >= trial) begin
                    r_v   <= r_v - trial;
                    r_res <= (r_res >> 1) + bitv;
                end else begin
                    r_res <= r_res >> 1;
                end
                if (r_cnt == 5'(tcf_pkg::SQRT_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 5'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[23:0];
endmodule
`default_nettype wire
